// ===== hdl/timed_event_queue_core_macros.svh =====
// Assertion macros for the port checker of the timed event queue.
`ifndef TIMED_EVENT_QUEUE_CORE_MACROS_SVH
`define TIMED_EVENT_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TEQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("timed event queue port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("timed event queue port check failed");

`endif

// ===== hdl/tevq_pkg.sv =====
// Package with widths, codes and shared types of the timed event queue.
`timescale 1ns / 1ps
package tevq_pkg;

    localparam int TIME_W   = 64;
    localparam int ID_W     = 4;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int CFG_W    = 16;

    localparam int DEPTH_DEFAULT = 16;
    localparam logic [CFG_W-1:0] IDLE_ADVANCE_RST = 16'd16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SCHED  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LATE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

    // Input tdata layout: event_id, event_time, now
    localparam int IN_ID_LSB   = 0;
    localparam int IN_TIME_LSB = IN_ID_LSB + ID_W;
    localparam int IN_NOW_LSB  = IN_TIME_LSB + TIME_W;
    localparam int IN_BITS     = IN_NOW_LSB + TIME_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout: head_id, head_time, target_stamp, pending_count
    localparam int OUT_HID_LSB    = 0;
    localparam int OUT_HTIME_LSB  = OUT_HID_LSB + ID_W;
    localparam int OUT_TARGET_LSB = OUT_HTIME_LSB + TIME_W;
    localparam int OUT_COUNT_LSB  = OUT_TARGET_LSB + TIME_W;
    localparam int OUT_BITS       = OUT_COUNT_LSB + COUNT_W;
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the accepted item
        logic commit;  // apply the command and load the result register
    } tevq_cmd_t;

endpackage

// ===== hdl/tevq_ctrl.sv =====
// Controller state machine: accept, evaluate, hand off the result.
`timescale 1ns / 1ps
module tevq_ctrl
    import tevq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output tevq_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.load   = s_tvalid && s_tready;
    // hold in evaluate until the result register is free
    assign cmd.commit = (state_reg == S_EVAL) && (!m_tvalid_reg || m_tready);
    assign m_tvalid   = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (cmd.commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== hdl/tevq_dp.sv =====
// Datapath: sorted slot array, per-slot compares, target and result registers.
`timescale 1ns / 1ps
module tevq_dp
    import tevq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tevq_cmd_t           cmd,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic [CMD_W-1:0]    in_cmd,
    input  logic [ID_W-1:0]     in_id,
    input  logic [TIME_W-1:0]   in_time,
    input  logic [TIME_W-1:0]   in_now,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     head_id,
    output logic [TIME_W-1:0]   head_time,
    output logic [TIME_W-1:0]   target_stamp,
    output logic [COUNT_W-1:0]  pending_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    // captured item
    logic [CMD_W-1:0]  cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] now_reg;

    logic [CFG_W-1:0]  idle_adv_reg;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [TIME_W-1:0] target_reg, target_next;

    logic [TIME_W-1:0] slot_time_reg [DEPTH];
    logic [ID_W-1:0]   slot_id_reg   [DEPTH];
    logic [TIME_W-1:0] slot_time_next [DEPTH];
    logic [ID_W-1:0]   slot_id_next   [DEPTH];

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     hid_reg, hid_next;
    logic [TIME_W-1:0]   htime_reg, htime_next;
    logic [TIME_W-1:0]   tgt_out_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [DEPTH-1:0] valid, match, less, past, rm_shift;
    logic [IDX_W-1:0] match_pos, rm_pos;
    logic found, cancel_late, empty, full, sched_late;
    logic do_ins, do_rm;

    // per-slot compares, each slot against the captured item
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            valid[i] = CNT_W'(i) < occ_reg;
            match[i] = valid[i] && (slot_id_reg[i] == id_reg);
            less[i]  = valid[i] && (slot_time_reg[i] < time_reg);
            past[i]  = slot_time_reg[i] < now_reg;
        end
    end

    // encode the matching slot (ids are unique, so at most one hit)
    always_comb begin
        match_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match_pos = match_pos | (match[i] ? IDX_W'(i) : '0);
        end
    end

    assign found       = |match;
    assign cancel_late = |(match & past);
    assign empty       = (occ_reg == '0);
    assign full        = (occ_reg >= CNT_W'(DEPTH));
    assign sched_late  = time_reg < now_reg;
    assign rm_pos      = (cmd_reg == CMD_CANCEL) ? match_pos : '0;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            rm_shift[i] = IDX_W'(i) >= rm_pos;
        end
    end

    // decide the outcome
    always_comb begin
        status_next = ST_OK;
        hid_next    = '0;
        htime_next  = '0;
        do_ins      = 1'b0;
        do_rm       = 1'b0;
        case (cmd_reg)
            CMD_SCHED: begin
                if (sched_late) begin
                    status_next = ST_LATE;
                end else if (found) begin
                    status_next = ST_DUP;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            CMD_CANCEL: begin
                if (!found) begin
                    status_next = ST_UNKNOWN;
                end else if (cancel_late) begin
                    status_next = ST_LATE;
                end else begin
                    do_rm = 1'b1;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    hid_next   = slot_id_reg[0];
                    htime_next = slot_time_reg[0];
                    if (cmd_reg == CMD_POP) begin
                        if (past[0]) begin
                            status_next = ST_LATE;
                        end else begin
                            do_rm = 1'b1;
                        end
                    end
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // next contents of each slot: insert shifts toward the tail, remove toward the head
    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        logic              at_pos;
        logic [TIME_W-1:0] up_time, dn_time;
        logic [ID_W-1:0]   up_id, dn_id;

        if (i == 0) begin : g_first
            assign at_pos  = !less[0];
            assign up_time = time_reg;
            assign up_id   = id_reg;
        end else begin : g_rest
            assign at_pos  = less[i-1] && !less[i];
            assign up_time = slot_time_reg[i-1];
            assign up_id   = slot_id_reg[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign dn_time = slot_time_reg[i];
            assign dn_id   = slot_id_reg[i];
        end else begin : g_inner
            assign dn_time = slot_time_reg[i+1];
            assign dn_id   = slot_id_reg[i+1];
        end

        assign slot_time_next[i] =
            do_ins ? (less[i] ? slot_time_reg[i] : (at_pos ? time_reg : up_time)) :
            (do_rm && rm_shift[i]) ? dn_time : slot_time_reg[i];
        assign slot_id_next[i] =
            do_ins ? (less[i] ? slot_id_reg[i] : (at_pos ? id_reg : up_id)) :
            (do_rm && rm_shift[i]) ? dn_id : slot_id_reg[i];
    end

    always_comb begin
        occ_next    = occ_reg;
        target_next = target_reg;
        if (do_ins) begin
            occ_next = occ_reg + CNT_W'(1);
        end else if (do_rm) begin
            occ_next = occ_reg - CNT_W'(1);
        end
        if (do_ins || do_rm) begin
            target_next = (occ_next != '0) ? slot_time_next[0]
                                           : now_reg + TIME_W'(idle_adv_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg  <= in_cmd;
            id_reg   <= in_id;
            time_reg <= in_time;
            now_reg  <= in_now;
        end
        if (cmd.commit) begin
            if (do_ins || do_rm) begin
                for (int i = 0; i < DEPTH; i++) begin
                    slot_time_reg[i] <= slot_time_next[i];
                    slot_id_reg[i]   <= slot_id_next[i];
                end
            end
            status_reg  <= status_next;
            hid_reg     <= hid_next;
            htime_reg   <= htime_next;
            tgt_out_reg <= target_next;
            count_reg   <= COUNT_W'(occ_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_adv_reg <= IDLE_ADVANCE_RST;
            occ_reg      <= '0;
            target_reg   <= '0;
        end else begin
            if (cfg_we) begin
                idle_adv_reg <= cfg_wdata;
            end
            if (cmd.commit) begin
                occ_reg    <= occ_next;
                target_reg <= target_next;
            end
        end
    end

    assign status        = status_reg;
    assign head_id       = hid_reg;
    assign head_time     = htime_reg;
    assign target_stamp  = tgt_out_reg;
    assign pending_count = count_reg;

endmodule

// ===== hdl/timed_event_queue_core.sv =====
// Top level of the timed event queue: sorted timer events with stream ports.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_tvalid/s_tready   s_tuser = cmd, s_tdata = id, time, now
//  m_        out        m_tvalid/m_tready   m_tuser = status, m_tdata = head and target
//  cfg_      in         cfg_we              cfg_wdata = idle_advance
//
//  Each item is first captured, then compared against every slot in parallel while
//  the sorted slot array is updated, so a new item is not accepted until the last
//  one has been evaluated. The evaluate cycle holds while an earlier result is not yet
//  taken; a new item is accepted while a result waits on the output.
//  Synchronous active-low reset empties the queue, zeroes the target and sets
//  idle_advance to 16; slot contents are not cleared.
//
module timed_event_queue_core
    import tevq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,    // idle_advance
    // command items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,      // event_id[3:0], event_time[67:4], now[131:68]
    input  logic [CMD_W-1:0]       s_tuser,      // cmd[1:0]
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,      // head_id[3:0], head_time[67:4],
                                                 // target_stamp[131:68], pending_count[136:132]
    output logic [STATUS_W-1:0]    m_tuser       // status[2:0]
);

    tevq_cmd_t ctl_cmd;

    logic [ID_W-1:0]     head_id;
    logic [TIME_W-1:0]   head_time;
    logic [TIME_W-1:0]   target_stamp;
    logic [COUNT_W-1:0]  pending_count;

    // sequence accept, evaluate and hand-off
    tevq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (ctl_cmd)
    );

    // slot array, compares and result register
    tevq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (ctl_cmd),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_cmd        (s_tuser),
        .in_id         (s_tdata[IN_TIME_LSB-1:IN_ID_LSB]),
        .in_time       (s_tdata[IN_NOW_LSB-1:IN_TIME_LSB]),
        .in_now        (s_tdata[IN_BITS-1:IN_NOW_LSB]),
        .status        (m_tuser),
        .head_id       (head_id),
        .head_time     (head_time),
        .target_stamp  (target_stamp),
        .pending_count (pending_count)
    );

    // pack the result fields, zero the pad bits
    assign m_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                      pending_count, target_stamp, head_time, head_id};

endmodule

// ===== hdl/tevq_checker.sv =====
// Port checker for the timed event queue, bound to the top level.
`timescale 1ns / 1ps
`include "timed_event_queue_core_macros.svh"
module tevq_checker
    import tevq_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]    m_tuser
);

    // a stalled result holds
    `TEQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one item at a time: no accept right after an accept
    `TEQ_ASSERT_NEXT(a_accept_gap, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // an empty result shows no head and no pending events
    `TEQ_ASSERT_IMPL(a_empty_fields, aclk, aresetn, m_tvalid && (m_tuser == ST_EMPTY), (m_tdata[OUT_TARGET_LSB-1:OUT_HID_LSB] == '0) && (m_tdata[OUT_BITS-1:OUT_COUNT_LSB] == '0))

    // unique ids bound the pending count
    `TEQ_ASSERT_IMPL(a_count_bound, aclk, aresetn, m_tvalid, m_tdata[OUT_BITS-1:OUT_COUNT_LSB] <= COUNT_W'(16))

endmodule

bind timed_event_queue_core tevq_checker u_tevq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tevq_result_checker.sv =====
// Checker for the timed event queue: mirrors the sorted queue and compares every result item.
`timescale 1ns / 1ps
module tevq_result_checker
    import tevq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]       s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic [STATUS_W-1:0]    m_tuser,
    output int                     fail_count,
    output int                     pending_results
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     head_id;
        logic [TIME_W-1:0]   head_time;
        logic [TIME_W-1:0]   target;
        logic [COUNT_W-1:0]  count;
    } queue_resp_t;

    // Mirror of the pending events, earliest first in slots 0 .. ev_count-1
    logic [TIME_W-1:0] ev_time [DEPTH];
    logic [ID_W-1:0]   ev_id   [DEPTH];
    int                ev_count;
    logic [TIME_W-1:0] tgt_stamp;
    logic [CFG_W-1:0]  idle_adv;

    queue_resp_t due_results [$];
    int          mismatches;

    assign fail_count = mismatches;

    initial pending_results = 0;

    function automatic int find_slot(logic [ID_W-1:0] id);
        for (int i = 0; i < ev_count; i++) begin
            if (ev_id[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < ev_count; i++) begin
            ev_time[i] = ev_time[i + 1];
            ev_id[i]   = ev_id[i + 1];
        end
        ev_count--;
    endfunction

    function automatic void refresh_target(logic [TIME_W-1:0] now);
        if (ev_count > 0) tgt_stamp = ev_time[0];
        else tgt_stamp = now + TIME_W'(idle_adv);
    endfunction

    function automatic queue_resp_t apply_command(logic [CMD_W-1:0] op, logic [ID_W-1:0] id,
                                                  logic [TIME_W-1:0] due,
                                                  logic [TIME_W-1:0] now);
        queue_resp_t r;
        int          pos;
        int          ins;
        r        = '0;
        r.status = ST_OK;
        pos      = find_slot(id);
        ins      = 0;
        case (op)
            CMD_SCHED: begin
                if (due < now) begin
                    r.status = ST_LATE;
                end else if (pos >= 0) begin
                    r.status = ST_DUP;
                end else if (ev_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // equal times: the new event goes ahead
                    while (ins < ev_count && ev_time[ins] < due) ins++;
                    for (int i = ev_count; i > ins; i--) begin
                        ev_time[i] = ev_time[i - 1];
                        ev_id[i]   = ev_id[i - 1];
                    end
                    ev_time[ins] = due;
                    ev_id[ins]   = id;
                    ev_count++;
                    refresh_target(now);
                end
            end
            CMD_CANCEL: begin
                if (pos < 0) begin
                    r.status = ST_UNKNOWN;
                end else if (ev_time[pos] < now) begin
                    r.status = ST_LATE;
                end else begin
                    drop_slot(pos);
                    refresh_target(now);
                end
            end
            default: begin
                if (ev_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.head_id   = ev_id[0];
                    r.head_time = ev_time[0];
                    if (op == CMD_POP) begin
                        if (ev_time[0] < now) begin
                            r.status = ST_LATE;
                        end else begin
                            drop_slot(0);
                            refresh_target(now);
                        end
                    end
                end
            end
        endcase
        r.target = tgt_stamp;
        r.count  = COUNT_W'(ev_count);
        return r;
    endfunction

    always @(posedge aclk) begin
        queue_resp_t got;
        queue_resp_t want;
        if (!aresetn) begin
            ev_count  = 0;
            tgt_stamp = '0;
            idle_adv  = IDLE_ADVANCE_RST;
            due_results.delete();
            mismatches = 0;
        end else begin
            if (cfg_we) idle_adv = cfg_wdata;

            // compare before predicting, so a stray result never meets this cycle's item
            if (m_tvalid && m_tready) begin
                got.status    = m_tuser;
                got.head_id   = m_tdata[OUT_HID_LSB +: ID_W];
                got.head_time = m_tdata[OUT_HTIME_LSB +: TIME_W];
                got.target    = m_tdata[OUT_TARGET_LSB +: TIME_W];
                got.count     = m_tdata[OUT_COUNT_LSB +: COUNT_W];
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: status %0d head %0d/%h target %h count %0d",
                                 got.status, got.head_id, got.head_time, got.target, got.count);
                end else begin
                    want = due_results.pop_front();
                    if (got.status != want.status || got.head_id != want.head_id ||
                        got.head_time != want.head_time || got.target != want.target ||
                        got.count != want.count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch (expected / actual): status %0d / %0d, head_id %0d / %0d",
                                     want.status, got.status, want.head_id, got.head_id);
                            $display("  head_time %h / %h, target %h / %h, count %0d / %0d",
                                     want.head_time, got.head_time, want.target, got.target,
                                     want.count, got.count);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
                due_results.push_back(apply_command(s_tuser,
                                                    s_tdata[IN_ID_LSB +: ID_W],
                                                    s_tdata[IN_TIME_LSB +: TIME_W],
                                                    s_tdata[IN_NOW_LSB +: TIME_W]));
        end
        pending_results <= due_results.size();
    end

endmodule

// ===== tb/tb_timed_event_queue_core.sv =====
// Testbench top of the timed event queue: stimulus, idling, configuration and the verdict.
`timescale 1ns / 1ps
module tb_timed_event_queue_core;
    import tevq_pkg::*;

    localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};
    // Run length limit; allow a wide margin.
    localparam int CYCLE_LIMIT = 200000;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    int   fail_count;
    int   pending_results;
    int   cycle_count = 0;
    int   rx_hold = 0;
    logic calm = 1'b0;   // set for the closing phase: no idling on either side

    always #5 aclk = ~aclk;

    timed_event_queue_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    tevq_result_checker u_result_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: now and then stall for a random burst, otherwise take every item.
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_hold  <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one command item and hold it until the block takes it. Leave tvalid high
    // afterwards so that back-to-back items follow without a gap in tvalid.
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] due, input logic [TIME_W-1:0] now);
        logic [IN_TDATA_W-1:0] pkt;
        pkt = '0;
        pkt[IN_ID_LSB +: ID_W]     = id;
        pkt[IN_TIME_LSB +: TIME_W] = due;
        pkt[IN_NOW_LSB +: TIME_W]  = now;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= pkt;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop tvalid and hold until every expected result item has arrived, then let the
    // block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_idle_advance(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Pop with now at zero until the queue must be empty; stale events never block this.
    task automatic flush_queue();
        for (int k = 0; k < DEPTH_DEFAULT + 1; k++)
            send_item(CMD_POP, ID_W'($urandom), {$urandom, $urandom}, '0);
    endtask

    // Random commands around an epoch: kind 0 near zero, 1 anywhere, 2 near the top of the
    // 64-bit range. Times cluster close to now so that events get popped and cancelled
    // while still due; a rewind to the epoch now and then frees events gone stale.
    task automatic run_phase(input int n_items, input int kind);
        logic [TIME_W-1:0] epoch;
        logic [TIME_W-1:0] clk_now;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] due;
        logic [CMD_W-1:0]  op;
        int                pick;
        int                shape;
        case (kind)
            0:       epoch = TIME_W'($urandom_range(0, 50));
            1:       epoch = {$urandom, $urandom};
            default: epoch = T_MAX - TIME_W'($urandom_range(2000, 5000));
        endcase
        clk_now = epoch;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      op = CMD_SCHED;
            else if (pick < 65) op = CMD_CANCEL;
            else if (pick < 85) op = CMD_POP;
            else                op = CMD_PEEK;
            clk_now = clk_now + TIME_W'($urandom_range(0, 3));
            now = clk_now;
            if ($urandom_range(0, 11) == 0) now = epoch;
            if ($urandom_range(0, 32) == 0) now = {$urandom, $urandom};
            shape = $urandom_range(0, 99);
            if (shape < 8)       due = now - TIME_W'($urandom_range(1, 20));
            else if (shape < 20) due = {$urandom, $urandom};
            else if (shape < 35) due = epoch + TIME_W'(32 * $urandom_range(0, 8));
            else                 due = now + TIME_W'($urandom_range(0, 300));
            send_item(op, ID_W'($urandom_range(0, 15)), due, now);
        end
        flush_queue();
    endtask

    initial begin
        // Known values on every input before the first edge.
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tuser   = CMD_PEEK;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty queue: peek, pop and cancel all fail; the target stays at its reset value.
        send_item(CMD_PEEK, 4'd0, '0, 64'd5);
        send_item(CMD_POP, 4'd0, '0, 64'd5);
        send_item(CMD_CANCEL, 4'd3, '0, 64'd5);
        // Extreme times, a late schedule, a duplicate id, and a tie that goes ahead.
        send_item(CMD_SCHED, 4'd0, T_MAX, '0);
        send_item(CMD_SCHED, 4'd15, '0, '0);
        send_item(CMD_SCHED, 4'd5, 64'd50, 64'd100);
        send_item(CMD_SCHED, 4'd15, 64'd200, '0);
        send_item(CMD_SCHED, 4'd7, '0, '0);
        send_item(CMD_PEEK, 4'd0, '0, '0);
        // Late pop and late cancel keep the queue; the same commands on time succeed.
        send_item(CMD_POP, 4'd0, '0, 64'd1);
        send_item(CMD_POP, 4'd0, '0, '0);
        send_item(CMD_CANCEL, 4'd15, '0, 64'd1);
        send_item(CMD_CANCEL, 4'd15, '0, '0);
        send_item(CMD_CANCEL, 4'd15, '0, '0);
        // Fill all sixteen ids, each new one landing at the head.
        for (int i = 1; i < 16; i++)
            send_item(CMD_SCHED, ID_W'(i), TIME_W'(1000 - 10 * i), '0);
        send_item(CMD_SCHED, 4'd9, 64'd5, '0);
        send_item(CMD_POP, 4'd0, '0, T_MAX);

        // Largest idle advance; the pop with now near the top empties the queue and wraps the target.
        write_idle_advance(16'hFFFF);
        for (int i = 0; i < 15; i++) send_item(CMD_POP, 4'd0, '0, '0);
        send_item(CMD_POP, 4'd0, '0, T_MAX - 64'd3);
        send_item(CMD_POP, 4'd0, '0, '0);

        write_idle_advance(16'd1);
        run_phase(80, 0);
        write_idle_advance(CFG_W'($urandom_range(1, 65535)));
        run_phase(75, 1);
        write_idle_advance(16'hFFFF);
        run_phase(75, 2);
        write_idle_advance(IDLE_ADVANCE_RST);
        calm = 1'b1;
        run_phase(60, 0);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
